@@ rtl/srbs_pkg.sv @@
`default_nettype none

package srbs_pkg;

    localparam int NUM_BUTTONS = 8;
    localparam int ID_W        = 16;
    localparam int CFG_IDX_W   = 8;
    localparam int CFG_DATA_W  = 64;

    typedef logic [NUM_BUTTONS-1:0]           btn_mask_t;
    typedef logic [NUM_BUTTONS-1:0][ID_W-1:0] id_table_t;

    // Register indexes of the configuration port.
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_ID_MAP_LOW  = 8'd0,
        REG_ID_MAP_HIGH = 8'd1,
        REG_INV_MASK    = 8'd2,
        REG_SCAN_ENABLE = 8'd3
    } cfg_reg_t;

    localparam logic EV_PRESS   = 1'b0;
    localparam logic EV_RELEASE = 1'b1;

    // A finished scan as handed from the shift stage to the event emitter.
    typedef struct packed {
        logic      valid;
        btn_mask_t pending;  // changed and mapped buttons
        btn_mask_t scanned;  // new pressed state
    } scan_t;

endpackage

`default_nettype wire

@@ rtl/srbs_scan.sv @@
`default_nettype none

module srbs_scan #(
    parameter int SCAN_LEN = 8
) (
    input  wire                    clk,
    input  wire                    rst_n,
    input  wire                    in_valid,
    output logic                   in_ready,
    input  wire                    data_bit,
    input  wire                    scan_enable,
    input  wire srbs_pkg::btn_mask_t inv_mask,
    input  wire srbs_pkg::btn_mask_t mapped,
    input  wire                    emit_busy,
    output srbs_pkg::scan_t        scan
);
    import srbs_pkg::*;

    localparam logic [2:0] LAST_CNT = 3'(SCAN_LEN - 1);

    btn_mask_t  shift_bits_reg, shift_bits_next;
    logic [2:0] bit_counter_reg, bit_counter_next;
    btn_mask_t  pressed_reg, pressed_next;

    logic      completing;
    logic      take;
    btn_mask_t shifted;
    btn_mask_t scanned;
    btn_mask_t changed;

    assign completing = (bit_counter_reg == LAST_CNT);
    // A scan may only finish once the emitter has drained the previous one.
    assign in_ready   = !scan_enable || !(completing && emit_busy);
    assign take       = in_valid && in_ready && scan_enable;

    assign shifted = {shift_bits_reg[NUM_BUTTONS-2:0], data_bit};
    assign scanned = shifted ^ inv_mask;
    assign changed = scanned ^ pressed_reg;

    always_comb
    begin
        shift_bits_next  = shift_bits_reg;
        bit_counter_next = bit_counter_reg;
        pressed_next     = pressed_reg;
        scan.valid       = 1'b0;
        scan.pending     = changed & mapped;
        scan.scanned     = scanned;
        if (take)
        begin
            if (completing)
            begin
                shift_bits_next  = '0;
                bit_counter_next = '0;
                pressed_next     = scanned;
                scan.valid       = 1'b1;
            end
            else
            begin
                shift_bits_next  = shifted;
                bit_counter_next = bit_counter_reg + 3'd1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            shift_bits_reg  <= '0;
            bit_counter_reg <= '0;
            pressed_reg     <= '0;
        end
        else
        begin
            shift_bits_reg  <= shift_bits_next;
            bit_counter_reg <= bit_counter_next;
            pressed_reg     <= pressed_next;
        end
    end

endmodule

`default_nettype wire

@@ rtl/srbs_emit.sv @@
`default_nettype none

module srbs_emit (
    input  wire                          clk,
    input  wire                          rst_n,
    input  wire srbs_pkg::scan_t         scan,
    input  wire srbs_pkg::id_table_t     id_map,
    output logic                         busy,
    output logic                         out_valid,
    input  wire                          out_ready,
    output logic                         event_kind,
    output logic [srbs_pkg::ID_W-1:0]    button_id,
    output logic                         last
);
    import srbs_pkg::*;

    btn_mask_t pending_reg, pending_next;
    btn_mask_t scanned_reg, scanned_next;
    logic      phase_reg, phase_next;   // 0: mapped id event, 1: any-key event
    logic      out_valid_reg, out_valid_next;
    logic      kind_reg, kind_next;
    logic [ID_W-1:0] id_reg, id_next;
    logic      last_reg, last_next;

    logic [2:0] cur;
    logic       emit;
    logic       only_one;

    always_comb
    begin
        cur = '0;
        for (int i = NUM_BUTTONS - 1; i >= 0; i--)
        begin
            if (pending_reg[i])
            begin
                cur = 3'(i);
            end
        end
    end

    assign busy     = (pending_reg != '0);
    assign only_one = ((pending_reg & (pending_reg - btn_mask_t'(1))) == '0);
    assign emit     = busy && (!out_valid_reg || out_ready);

    always_comb
    begin
        pending_next   = pending_reg;
        scanned_next   = scanned_reg;
        phase_next     = phase_reg;
        out_valid_next = out_valid_reg && !out_ready;
        kind_next      = kind_reg;
        id_next        = id_reg;
        last_next      = last_reg;
        if (scan.valid)
        begin
            pending_next = scan.pending;
            scanned_next = scan.scanned;
            phase_next   = 1'b0;
        end
        else if (emit)
        begin
            out_valid_next = 1'b1;
            kind_next      = scanned_reg[cur] ? EV_PRESS : EV_RELEASE;
            id_next        = phase_reg ? '0 : id_map[cur];
            last_next      = phase_reg && only_one;
            if (phase_reg)
            begin
                pending_next[cur] = 1'b0;
                phase_next        = 1'b0;
            end
            else
            begin
                phase_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pending_reg   <= '0;
            phase_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            pending_reg   <= pending_next;
            phase_reg     <= phase_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        scanned_reg <= scanned_next;
        kind_reg    <= kind_next;
        id_reg      <= id_next;
        last_reg    <= last_next;
    end

    assign out_valid  = out_valid_reg;
    assign event_kind = kind_reg;
    assign button_id  = id_reg;
    assign last       = last_reg;

endmodule

`default_nettype wire

@@ rtl/shift_register_button_scanner_core.sv @@
`default_nettype none

// Channel   Direction  Handshake              Payload
// in        input      in_valid / in_ready    data_bit
// out       output     out_valid / out_ready  event_kind, button_id, last
// cfg       input      cfg_valid / cfg_ready  cfg_index, cfg_data
//
// One serial bit is taken per cycle when enabled and in_ready is high; the scan
// finishes on the SCAN_LEN-th bit. A changed scan queues its events in the emitter,
// which issues one event per cycle from its output register as out_ready allows,
// two per changed mapped button. in_ready drops only when a scan would finish while
// the emitter still holds events of the previous scan. cfg_ready is always high.
// Reset clears shift state, pressed state and the emitter; scan_enable resets to 1.
module shift_register_button_scanner_core #(
    parameter int SCAN_BITS = 8
) (
    input  wire                                clk,
    input  wire                                rst_n,
    input  wire                                in_valid,
    output logic                               in_ready,
    input  wire                                data_bit,
    output logic                               out_valid,
    input  wire                                out_ready,
    output logic                               event_kind,
    output logic [srbs_pkg::ID_W-1:0]          button_id,
    output logic                               last,
    input  wire                                cfg_valid,
    output logic                               cfg_ready,
    input  wire  [srbs_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  wire  [srbs_pkg::CFG_DATA_W-1:0]    cfg_data
);
    import srbs_pkg::*;

    localparam int SCAN_LEN = (SCAN_BITS < 1) ? 1 :
                              ((SCAN_BITS > NUM_BUTTONS) ? NUM_BUTTONS : SCAN_BITS);

    logic [CFG_DATA_W-1:0] id_map_low_reg;
    logic [CFG_DATA_W-1:0] id_map_high_reg;
    btn_mask_t             inv_mask_reg;
    logic                  scan_enable_reg;

    id_table_t id_map;
    btn_mask_t mapped;
    scan_t     scan;
    logic      emit_busy;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            id_map_low_reg  <= '0;
            id_map_high_reg <= '0;
            inv_mask_reg    <= '0;
            scan_enable_reg <= 1'b1;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                REG_ID_MAP_LOW:  id_map_low_reg  <= cfg_data;
                REG_ID_MAP_HIGH: id_map_high_reg <= cfg_data;
                REG_INV_MASK:    inv_mask_reg    <= cfg_data[NUM_BUTTONS-1:0];
                REG_SCAN_ENABLE: scan_enable_reg <= cfg_data[0];
                default:         ;
            endcase
        end
    end

    assign id_map = {id_map_high_reg, id_map_low_reg};

    always_comb
    begin
        for (int i = 0; i < NUM_BUTTONS; i++)
        begin
            mapped[i] = (id_map[i] != '0);
        end
    end

    srbs_scan #(
        .SCAN_LEN (SCAN_LEN)
    ) u_scan (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .data_bit    (data_bit),
        .scan_enable (scan_enable_reg),
        .inv_mask    (inv_mask_reg),
        .mapped      (mapped),
        .emit_busy   (emit_busy),
        .scan        (scan)
    );

    srbs_emit u_emit (
        .clk        (clk),
        .rst_n      (rst_n),
        .scan       (scan),
        .id_map     (id_map),
        .busy       (emit_busy),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .event_kind (event_kind),
        .button_id  (button_id),
        .last       (last)
    );

    // The final event of a scan is always the any-key event.
    a_last_is_any_key: assert property (
        @(posedge clk) disable iff (!rst_n)
        out_valid |-> (!last || button_id == '0))
        else $error("last event carries a mapped id");

    // A mapped id event is followed directly by its any-key event of the same kind.
    a_any_key_follows: assert property (
        @(posedge clk) disable iff (!rst_n)
        (out_valid && out_ready && button_id != '0)
            |=> (out_valid && button_id == '0 && $stable(event_kind)))
        else $error("any-key event missing after mapped event");

    // A scan never completes while scanning is disabled or events are still queued.
    a_no_scan_overrun: assert property (
        @(posedge clk) disable iff (!rst_n)
        scan.valid |-> (scan_enable_reg && !emit_busy))
        else $error("scan completed over pending events");

endmodule

`default_nettype wire
